@@ design/polyline_point_at_distance_assert.svh @@
// Assertion macros used by the polyline point-at-distance controller.
// Expects signals clk and rst_n in the scope of each use.
`ifndef POLYLINE_POINT_AT_DISTANCE_ASSERT_SVH
`define POLYLINE_POINT_AT_DISTANCE_ASSERT_SVH

// Same-cycle implication.
`define PPAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ppad_pkg.sv @@
// Types and constants for the polyline point-at-distance block.
// No dependencies.
package ppad_pkg;

    localparam int COORD_W = 24;
    localparam int PT_W    = 3 * COORD_W;
    localparam int DIST_W  = 32;
    localparam int CNT_O_W = 9;
    localparam int MAG_W   = COORD_W + 1;
    localparam int ROOT_W  = 25;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int PROD_W  = MAG_W + DIST_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int Q_W     = 25;
    localparam int IT_W    = 5;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_e_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CLAMPED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_e_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_CLEAR, DP_RD_LAST, DP_RD_JM1, DP_RD_J,
        DP_LATCH_A, DP_LATCH_B, DP_SQ, DP_SQRT_INIT, DP_SQRT_STEP,
        DP_APPEND, DP_SCAN_RD, DP_SCAN_CHK, DP_MUL, DP_DIV_INIT,
        DP_DIV_STEP, DP_DIV_DONE, DP_CLAMP, DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        status_e_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic full;
        logic scan_none;
        logic hit;
        logic scan_last;
        logic it_last;
        logic cidx_last;
    } dp_stat_t;

    // Point word layout: x high, z low.
    function automatic logic signed [COORD_W-1:0] pt_coord(
        input logic [PT_W-1:0] p,
        input logic [1:0]      i
    );
        logic signed [COORD_W-1:0] c;
        case (i)
            2'd0:    c = p[3*COORD_W-1:2*COORD_W];
            2'd1:    c = p[2*COORD_W-1:COORD_W];
            default: c = p[COORD_W-1:0];
        endcase
        return c;
    endfunction

endpackage

@@ design/ppad_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ppad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ppad_dp.sv @@
// Datapath: point and length stores, shared multiplier, square-root and divide iterations.
// Depends on ppad_pkg and ppad_ram.
module ppad_dp import ppad_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic signed [COORD_W-1:0]  point_x,
    input  logic signed [COORD_W-1:0]  point_y,
    input  logic signed [COORD_W-1:0]  point_z,
    input  logic [DIST_W-1:0]          query_distance,
    output dp_stat_t                   st,
    output logic signed [COORD_W-1:0]  pos_x,
    output logic signed [COORD_W-1:0]  pos_y,
    output logic signed [COORD_W-1:0]  pos_z,
    output logic [1:0]                 status,
    output logic [CNT_O_W-1:0]         point_count
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0]      count_reg, j_reg;
    logic [1:0]         cidx_reg;
    logic [IT_W-1:0]    itc_reg;
    logic [PT_W-1:0]    in_pt_reg, pa_reg, pb_reg, pos_reg;
    logic [DIST_W-1:0]  dist_reg, last_cum_reg, prev_reg, t_reg, seg_reg;
    logic [SQ_W-1:0]    sq_acc_reg, rad_reg;
    logic [ROOT_W+1:0]  srem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIST_W-1:0]  drem_reg;
    logic [Q_W-1:0]     dnum_reg, q_reg;
    logic [PT_W-1:0]    out_pos_reg;
    logic [1:0]         out_status_reg;
    logic [CNT_O_W-1:0] out_count_reg;

    logic [PT_W-1:0]    pt_rd;
    logic [DIST_W-1:0]  cum_rd, cum_wr;
    logic [AW-1:0]      raddr;
    logic [CW-1:0]      cnt_m1, j_m1;

    logic signed [COORD_W-1:0] sel_a, sel_o;
    logic signed [MAG_W-1:0]   diff;
    logic [MAG_W-1:0]          mag;
    logic [DIST_W-1:0]         mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic [ROOT_W+3:0]         ssh, strial;
    logic                      sge;
    logic [DIST_W:0]           dsh;
    logic                      dge;
    logic [NUM_W-1:0]          num;
    logic [MAG_W-1:0]          lerp;
    logic [DIST_W:0]           total;

    assign cnt_m1 = count_reg - CW'(1);
    assign j_m1   = j_reg - CW'(1);

    always_comb
    begin
        case (cmd.op)
            DP_RD_LAST: raddr = cnt_m1[AW-1:0];
            DP_RD_JM1:  raddr = j_m1[AW-1:0];
            default:    raddr = j_reg[AW-1:0];
        endcase
    end

    // Other endpoint is the new point while squaring, the far point while interpolating.
    assign sel_a = pt_coord(pa_reg, cidx_reg);
    assign sel_o = (cmd.op == DP_SQ) ? pt_coord(in_pt_reg, cidx_reg) : pt_coord(pb_reg, cidx_reg);
    assign diff  = {sel_o[COORD_W-1], sel_o} - {sel_a[COORD_W-1], sel_a};
    assign mag   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign mul_b = (cmd.op == DP_SQ) ? DIST_W'(mag) : t_reg;
    assign mul_p = PROD_W'(mag) * PROD_W'(mul_b);

    assign ssh    = {srem_reg, rad_reg[SQ_W-1 -: 2]};
    assign strial = {2'b00, root_reg, 2'b01};
    assign sge    = ssh >= strial;

    assign dsh = {drem_reg, dnum_reg[Q_W-1]};
    assign dge = dsh >= {1'b0, seg_reg};

    assign num  = {1'b0, prod_reg} + NUM_W'(seg_reg >> 1);
    assign lerp = diff[MAG_W-1] ? ({sel_a[COORD_W-1], sel_a} - MAG_W'(q_reg))
                                : ({sel_a[COORD_W-1], sel_a} + MAG_W'(q_reg));

    assign total  = {1'b0, last_cum_reg} + (DIST_W + 1)'(root_reg);
    assign cum_wr = (count_reg == '0) ? '0 : (total[DIST_W] ? '1 : total[DIST_W-1:0]);

    ppad_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
        .clk   (clk),
        .we    (cmd.op == DP_APPEND),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_pt_reg),
        .raddr (raddr),
        .rdata (pt_rd)
    );

    ppad_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_cum_ram (
        .clk   (clk),
        .we    (cmd.op == DP_APPEND),
        .waddr (count_reg[AW-1:0]),
        .wdata (cum_wr),
        .raddr (raddr),
        .rdata (cum_rd)
    );

    assign st.cnt_zero  = (count_reg == '0);
    assign st.full      = (count_reg == CW'(MAX_POINTS));
    assign st.scan_none = (j_reg == count_reg);
    assign st.hit       = (cum_rd > dist_reg);
    assign st.scan_last = ((j_reg + CW'(1)) == count_reg);
    assign st.it_last   = (itc_reg == '0);
    assign st.cidx_last = (cidx_reg == 2'd2);

    // Control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            j_reg     <= '0;
            cidx_reg  <= '0;
            itc_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_LOAD:
                begin
                    j_reg    <= CW'(1);
                    cidx_reg <= '0;
                end
                DP_CLEAR:     count_reg <= '0;
                DP_APPEND:    count_reg <= count_reg + CW'(1);
                DP_SQ:        cidx_reg  <= cidx_reg + 2'd1;
                DP_DIV_DONE:  cidx_reg  <= cidx_reg + 2'd1;
                DP_SQRT_INIT: itc_reg   <= IT_W'(ROOT_W - 1);
                DP_DIV_INIT:  itc_reg   <= IT_W'(Q_W - 1);
                DP_SQRT_STEP: itc_reg   <= itc_reg - IT_W'(1);
                DP_DIV_STEP:  itc_reg   <= itc_reg - IT_W'(1);
                DP_SCAN_CHK:
                begin
                    if (!st.hit)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                in_pt_reg  <= {point_x, point_y, point_z};
                dist_reg   <= query_distance;
                prev_reg   <= '0;
                sq_acc_reg <= '0;
                pos_reg    <= '0;
            end
            DP_LATCH_A:
            begin
                pa_reg       <= pt_rd;
                last_cum_reg <= cum_rd;
            end
            DP_LATCH_B: pb_reg <= pt_rd;
            DP_SQ:      sq_acc_reg <= sq_acc_reg + mul_p[SQ_W-1:0];
            DP_SQRT_INIT:
            begin
                rad_reg  <= sq_acc_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            DP_SQRT_STEP:
            begin
                rad_reg <= rad_reg << 2;
                if (sge)
                begin
                    srem_reg <= (ROOT_W + 2)'(ssh - strial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= ssh[ROOT_W+1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            DP_SCAN_CHK:
            begin
                t_reg   <= dist_reg - prev_reg;
                seg_reg <= cum_rd - prev_reg;
                if (!st.hit)
                begin
                    prev_reg <= cum_rd;
                end
            end
            DP_MUL: prod_reg <= mul_p;
            DP_DIV_INIT:
            begin
                // Quotient fits Q_W bits, so the top part is already below the divisor.
                drem_reg <= num[DIST_W+Q_W-1:Q_W];
                dnum_reg <= num[Q_W-1:0];
                q_reg    <= '0;
            end
            DP_DIV_STEP:
            begin
                dnum_reg <= dnum_reg << 1;
                q_reg    <= {q_reg[Q_W-2:0], dge};
                drem_reg <= dge ? DIST_W'(dsh - {1'b0, seg_reg}) : dsh[DIST_W-1:0];
            end
            DP_DIV_DONE:
            begin
                case (cidx_reg)
                    2'd0:    pos_reg[3*COORD_W-1:2*COORD_W] <= lerp[COORD_W-1:0];
                    2'd1:    pos_reg[2*COORD_W-1:COORD_W]   <= lerp[COORD_W-1:0];
                    default: pos_reg[COORD_W-1:0]           <= lerp[COORD_W-1:0];
                endcase
            end
            DP_CLAMP: pos_reg <= pa_reg;
            DP_RESULT:
            begin
                out_pos_reg    <= pos_reg;
                out_status_reg <= cmd.status;
                out_count_reg  <= CNT_O_W'(count_reg);
            end
            default: ;
        endcase
    end

    assign pos_x       = out_pos_reg[3*COORD_W-1:2*COORD_W];
    assign pos_y       = out_pos_reg[2*COORD_W-1:COORD_W];
    assign pos_z       = out_pos_reg[COORD_W-1:0];
    assign status      = out_status_reg;
    assign point_count = out_count_reg;

endmodule

@@ design/ppad_ctrl.sv @@
// Controller state machine: sequences the datapath per item and owns the handshakes.
// Depends on ppad_pkg and the assertion macro header.
`include "polyline_point_at_distance_assert.svh"

module ppad_ctrl import ppad_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_stat_t   st,
    output dp_cmd_t    cmd
);

    typedef enum logic [19:0] {
        S_IDLE       = 20'h00001,
        S_DISPATCH   = 20'h00002,
        S_RD_LAST    = 20'h00004,
        S_LATCH_LAST = 20'h00008,
        S_SQ         = 20'h00010,
        S_SQRT_INIT  = 20'h00020,
        S_SQRT       = 20'h00040,
        S_APPEND     = 20'h00080,
        S_SCAN_RD    = 20'h00100,
        S_SCAN_CHK   = 20'h00200,
        S_RD_A       = 20'h00400,
        S_LATCH_A    = 20'h00800,
        S_RD_B       = 20'h01000,
        S_LATCH_B    = 20'h02000,
        S_MUL        = 20'h04000,
        S_DIV_INIT   = 20'h08000,
        S_DIV        = 20'h10000,
        S_DIV_DONE   = 20'h20000,
        S_CLAMP      = 20'h40000,
        S_DONE       = 20'h80000
    } state_t;

    state_t    state_reg, state_next;
    op_e_t     op_reg, op_next;
    status_e_t status_reg, status_next;
    logic      out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        cmd.op         = DP_NOP;
        cmd.status     = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op      = DP_LOAD;
                    op_next     = op_e_t'(op);
                    status_next = ST_OK;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_CLEAR:
                    begin
                        cmd.op     = DP_CLEAR;
                        state_next = S_DONE;
                    end
                    OP_APPEND:
                    begin
                        if (st.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (st.cnt_zero)
                        begin
                            state_next = S_APPEND;
                        end
                        else
                        begin
                            state_next = S_RD_LAST;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (st.cnt_zero)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else if (st.scan_none)
                        begin
                            status_next = ST_CLAMPED;
                            state_next  = S_RD_LAST;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RD_LAST:
            begin
                cmd.op     = DP_RD_LAST;
                state_next = S_LATCH_LAST;
            end
            S_LATCH_LAST:
            begin
                cmd.op     = DP_LATCH_A;
                state_next = (op_reg == OP_APPEND) ? S_SQ : S_CLAMP;
            end
            S_SQ:
            begin
                cmd.op = DP_SQ;
                if (st.cidx_last)
                begin
                    state_next = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = DP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = DP_SQRT_STEP;
                if (st.it_last)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.op     = DP_APPEND;
                state_next = S_DONE;
            end
            S_SCAN_RD:
            begin
                cmd.op     = DP_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.op = DP_SCAN_CHK;
                if (st.hit)
                begin
                    state_next = S_RD_A;
                end
                else if (st.scan_last)
                begin
                    status_next = ST_CLAMPED;
                    state_next  = S_RD_LAST;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_RD_A:
            begin
                cmd.op     = DP_RD_JM1;
                state_next = S_LATCH_A;
            end
            S_LATCH_A:
            begin
                cmd.op     = DP_LATCH_A;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.op     = DP_RD_J;
                state_next = S_LATCH_B;
            end
            S_LATCH_B:
            begin
                cmd.op     = DP_LATCH_B;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = DP_MUL;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = DP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = DP_DIV_STEP;
                if (st.it_last)
                begin
                    state_next = S_DIV_DONE;
                end
            end
            S_DIV_DONE:
            begin
                cmd.op     = DP_DIV_DONE;
                state_next = st.cidx_last ? S_DONE : S_MUL;
            end
            S_CLAMP:
            begin
                cmd.op     = DP_CLAMP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = DP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `PPAD_ASSERT_NEXT(a_accept_dispatch, in_valid && (state_reg == S_IDLE), state_reg == S_DISPATCH, "accepted transfer did not dispatch")
    `PPAD_ASSERT_NEXT(a_result_loads, (state_reg == S_DONE) && (!out_valid_reg || !out_stall), out_valid_reg && (state_reg == S_IDLE), "result not loaded")
    `PPAD_ASSERT_NOW(a_scan_nonempty, state_reg == S_SCAN_CHK, !st.cnt_zero && !st.scan_none, "segment scan on short polyline")
    `PPAD_ASSERT_NEXT(a_sqrt_exit, (state_reg == S_SQRT) && st.it_last, state_reg == S_APPEND, "root loop did not end in append")

endmodule

@@ design/polyline_point_at_distance.sv @@
// Top level of the polyline point-at-distance block: controller plus datapath.
// Depends on ppad_pkg, ppad_ctrl, ppad_dp (and ppad_ram through it).
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  input   | in_valid  | in_stall  | op, point_x/y/z, query_distance
//  output  | out_valid | out_stall | pos_x/y/z, status, point_count
//
// One item at a time. Clear, unused op, empty query and append to a full store go
// straight from dispatch to the result load. Append to an empty store writes the
// point directly; any other append first reads the last point and runs the 25-step
// square root. Query: one store read per segment scanned, then two reads plus three
// divisions when a segment hits, or a read of the last point when clamped.
// Reset clears the point count, sequencer and output valid; the stores need no
// clearing pass. A finished result sits in the output register, so a stalled output
// lets the next transfer in and holds it only when that one is done too.
module polyline_point_at_distance import ppad_pkg::*; #(
    parameter int MAX_POINTS = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic [DIST_W-1:0]         query_distance,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] pos_x,
    output logic signed [COORD_W-1:0] pos_y,
    output logic signed [COORD_W-1:0] pos_z,
    output logic [1:0]                status,
    output logic [CNT_O_W-1:0]        point_count
);

    dp_cmd_t  cmd;
    dp_stat_t st;

    // Sequencer: one state per datapath step.
    ppad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // Stores, multiplier, root and divide units, output register.
    ppad_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .query_distance (query_distance),
        .st             (st),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .status         (status),
        .point_count    (point_count)
    );

endmodule
